/* sv/cpsc_pkg.sv */
`timescale 1ns / 1ps
package cpsc_pkg;

  localparam int MaxFileBytes = 4194304;
  localparam int RegistryEntries = 16;
  localparam int RegistryMax = 16;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        tag;
    logic [22:0]        packet_size;
    logic [21:0]        packet_offset;
    logic [3:0]         status;
    logic signed [31:0] level_id;
    logic signed [31:0] health;
    logic signed [31:0] mode_field;
    logic signed [31:0] death_count;
    logic               final_res;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_ENV  = 3'd0,
    PH_HEAD = 3'd1,
    PH_BODY = 3'd2,
    PH_SENT = 3'd3,
    PH_HALT = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_SIZE      = 4'd2,
    ST_CHECKSUM  = 4'd3,
    ST_NO_SAVE   = 4'd4,
    ST_TRUNC     = 4'd5,
    ST_UNKNOWN   = 4'd6,
    ST_PKT_SIZE  = 4'd7,
    ST_NO_SEND   = 4'd8,
    ST_NO_GAME   = 4'd9,
    ST_LEVEL     = 4'd10,
    ST_HEALTH    = 4'd11
  } status_t;

  localparam logic [31:0] TagSave = 32'h45564153;
  localparam logic [31:0] TagSend = 32'h444e4553;
  localparam logic [31:0] TagGame = 32'h454d4147;

  function automatic logic [31:0] reg_tag(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h4f4d4544;
      1: t = 32'h444e4544;
      2: t = 32'h5359454b;
      3: t = 32'h45544152;
      4: t = 32'h45564153;
      5: t = 32'h444e4553;
      6: t = 32'h454d4147;
      7: t = 32'h424d4854;
      8: t = 32'h45524f4d;
      9: t = 32'h59414c50;
      10: t = 32'h504d4144;
      11: t = 32'h454d4143;
      12: t = 32'h4e455241;
      13: t = 32'h45494c41;
      14: t = 32'h444e4146;
      15: t = 32'h4c4c5542;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] reg_size(input int i);
    logic [31:0] s;
    case (i)
      2: s = 32'd20;
      3: s = 32'd4;
      4: s = 32'd2;
      6: s = 32'd24;
      7: s = 32'd3648;
      8: s = 32'd52;
      9: s = 32'd239;
      10: s = 32'd724;
      11: s = 32'd200;
      12: s = 32'd1126;
      13: s = 32'd814;
      14: s = 32'd72;
      15: s = 32'd252;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

endpackage

/* sv/cpsc_core.sv */
`timescale 1ns / 1ps
module cpsc_core #(
  parameter int MAX_FILE_BYTES = 4194304,
  parameter int REGISTRY_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             strict,
  input  logic             step,
  input  cpsc_pkg::in_item_t  item,
  output logic             rec_v,
  output cpsc_pkg::out_item_t rec,
  output logic             fin_v,
  output cpsc_pkg::out_item_t fin
);
  import cpsc_pkg::*;

  localparam int CW = $clog2(MAX_FILE_BYTES + 2);
  localparam int SW = $clog2(MAX_FILE_BYTES + 1);
  localparam int NREG = (REGISTRY_ENTRIES < RegistryMax) ? REGISTRY_ENTRIES : RegistryMax;
  localparam logic [CW-1:0] MaxB = CW'(MAX_FILE_BYTES);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] size_r, size_nxt, ssum_r, ssum_nxt, rsum_r, rsum_nxt;
  logic [7:0] key_r, key_nxt, kstep_r, kstep_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [SW-1:0] left_r, left_nxt;
  phase_t ph_r, ph_nxt;
  logic [3:0] err_r, err_nxt;
  logic [2:0] fl_r, fl_nxt;
  logic [31:0] gw_r [4];
  logic [31:0] gw_nxt [4];

  logic [CW-1:0] idx;
  logic [7:0] b, p;
  logic [31:0] tag, szw;
  logic [SW-1:0] cap, pos;
  logic [21:0] soff;
  logic hit, bad_sz, body_cnt;
  logic [31:0] lvl, hp;

  always_comb begin
    cnt_nxt = cnt_r; size_nxt = size_r; ssum_nxt = ssum_r; rsum_nxt = rsum_r;
    key_nxt = key_r; kstep_nxt = kstep_r; hdr_nxt = hdr_r; left_nxt = left_r;
    ph_nxt = ph_r; err_nxt = err_r; fl_nxt = fl_r;
    for (int k = 0; k < 4; k++) gw_nxt[k] = gw_r[k];
    rec_v = 1'b0; rec = '0; fin_v = 1'b0; fin = '0;
    idx = cnt_r; b = item.in_byte; p = b;
    tag = '0; szw = '0; cap = '0; pos = '0; hit = 1'b0; bad_sz = 1'b0;
    body_cnt = 1'b0; lvl = '0; hp = '0;
    soff = 22'(idx - CW'(8));
    if (step) begin
      if (idx < MaxB) begin
        if (idx < CW'(4)) size_nxt[8*idx[1:0] +: 8] = b;
        else if (idx < CW'(8)) ssum_nxt[8*idx[1:0] +: 8] = b;
        else rsum_nxt = rsum_r + 32'(b);
        if (idx == CW'(16)) key_nxt = b;
        if (idx == CW'(17)) kstep_nxt = b;
        if (idx >= CW'(18)) begin
          p = b ^ key_r;
          key_nxt = key_r + kstep_r;
        end
        if (idx >= CW'(8)) begin
          if (ph_r == PH_ENV || ph_r == PH_HEAD) begin
            hdr_nxt = {p, hdr_r[63:8]};
            if (ph_r == PH_ENV) left_nxt = SW'(7);
            else left_nxt = left_r - SW'(1);
            ph_nxt = PH_HEAD;
            if (left_nxt == '0) begin
              tag = hdr_nxt[31:0]; szw = hdr_nxt[63:32];
              cap = (szw > 32'(MAX_FILE_BYTES)) ? SW'(MAX_FILE_BYTES) : SW'(szw);
              if (soff == 22'd7 && (tag != TagSave || szw != 32'd2)) begin
                err_nxt = ST_NO_SAVE; ph_nxt = PH_HALT;
              end else begin
                for (int i = NREG - 1; i >= 0; i--)
                  if (reg_tag(i) == tag) begin
                    hit = 1'b1; bad_sz = (szw != reg_size(i));
                  end
                if (!hit) err_nxt = ST_UNKNOWN;
                else if (strict && bad_sz) err_nxt = ST_PKT_SIZE;
                fl_nxt[2] = (tag == TagGame) && !fl_r[0];
                left_nxt = cap;
                if (cap != '0) ph_nxt = PH_BODY;
                else body_cnt = 1'b1;
              end
            end
          end else if (ph_r == PH_BODY) begin
            tag = hdr_r[31:0]; szw = hdr_r[63:32];
            cap = (szw > 32'(MAX_FILE_BYTES)) ? SW'(MAX_FILE_BYTES) : SW'(szw);
            if (fl_r[2]) begin
              pos = cap - left_r;
              if (pos < SW'(4)) gw_nxt[0][8*pos[1:0] +: 8] = p;
              else if (pos < SW'(8)) gw_nxt[1][8*pos[1:0] +: 8] = p;
              else if (pos >= SW'(12) && pos < SW'(16)) gw_nxt[2][8*pos[1:0] +: 8] = p;
              else if (pos >= SW'(16) && pos < SW'(20)) gw_nxt[3][8*pos[1:0] +: 8] = p;
            end
            left_nxt = left_r - SW'(1);
            if (left_nxt == '0) body_cnt = 1'b1;
          end else if (ph_r == PH_SENT) begin
            err_nxt = ST_TRUNC; ph_nxt = PH_HALT;
          end
          if (body_cnt) begin
            if (err_nxt != '0) ph_nxt = PH_HALT;
            else begin
              rec_v = 1'b1;
              rec.tag = tag;
              rec.packet_size = 23'(cap);
              rec.packet_offset = 22'(soff + 22'd1 - 22'd8 - 22'(cap));
              if (fl_nxt[2]) begin
                fl_nxt[0] = 1'b1;
                if (cap < SW'(24)) fl_nxt[1] = 1'b1;
                fl_nxt[2] = 1'b0;
              end
              if (tag == TagSend) ph_nxt = PH_SENT;
              else begin
                ph_nxt = PH_HEAD; left_nxt = SW'(8);
              end
            end
          end
        end
        cnt_nxt = idx + CW'(1);
      end else begin
        cnt_nxt = MaxB + CW'(1);
      end
      if (item.last) begin
        fin_v = 1'b1;
        fin.kind = 1'b1; fin.final_res = 1'b1;
        fin.mode_field = gw_nxt[0]; fin.level_id = gw_nxt[1];
        fin.health = gw_nxt[2]; fin.death_count = gw_nxt[3];
        lvl = gw_nxt[1]; hp = gw_nxt[2];
        if (cnt_nxt < CW'(18) || cnt_nxt > MaxB) fin.status = ST_SHORT;
        else if (size_nxt != 32'(cnt_nxt)) fin.status = ST_SIZE;
        else if (ssum_nxt != rsum_nxt) fin.status = ST_CHECKSUM;
        else if (ph_nxt == PH_HALT) fin.status = err_nxt;
        else if (ph_nxt == PH_BODY) fin.status = ST_TRUNC;
        else if (ph_nxt != PH_SENT) fin.status = ST_NO_SEND;
        else if (!fl_nxt[0]) fin.status = ST_NO_GAME;
        else if (fl_nxt[1]) fin.status = ST_PKT_SIZE;
        else if ($signed(lvl) < 0 || $signed(lvl) >= 6) fin.status = ST_LEVEL;
        else if ($signed(hp) < 1 || $signed(hp) > 150) fin.status = ST_HEALTH;
        else fin.status = ST_OK;
        cnt_nxt = '0; size_nxt = '0; ssum_nxt = '0; rsum_nxt = '0;
        key_nxt = '0; kstep_nxt = '0; hdr_nxt = '0; left_nxt = '0;
        ph_nxt = PH_ENV; err_nxt = '0; fl_nxt = '0;
        for (int k = 0; k < 4; k++) gw_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; size_r <= '0; ssum_r <= '0; rsum_r <= '0;
      key_r <= '0; kstep_r <= '0; hdr_r <= '0; left_r <= '0;
      ph_r <= PH_ENV; err_r <= '0; fl_r <= '0;
      for (int k = 0; k < 4; k++) gw_r[k] <= '0;
    end else begin
      cnt_r <= cnt_nxt; size_r <= size_nxt; ssum_r <= ssum_nxt; rsum_r <= rsum_nxt;
      key_r <= key_nxt; kstep_r <= kstep_nxt; hdr_r <= hdr_nxt; left_r <= left_nxt;
      ph_r <= ph_nxt; err_r <= err_nxt; fl_r <= fl_nxt;
      for (int k = 0; k < 4; k++) gw_r[k] <= gw_nxt[k];
    end
  end
endmodule

/* sv/cpsc_outq.sv */
`timescale 1ns / 1ps
module cpsc_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_v,
  input  cpsc_pkg::out_item_t rec,
  input  logic                fin_v,
  input  cpsc_pkg::out_item_t fin,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output cpsc_pkg::out_item_t out_data
);
  import cpsc_pkg::*;

  // four-entry fifo; a transaction pushes up to two results
  out_item_t q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic pop;
  logic [1:0] npush;

  assign pop = out_valid && out_ready;
  assign npush = 2'(rec_v) + 2'(fin_v);
  assign cnt_nxt = cnt_r + 3'(npush) - 3'(pop);
  assign room = (cnt_r - 3'(pop)) <= 3'd2;
  assign out_valid = cnt_r != '0;
  assign out_data = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (rec_v) q_r[wr_r] <= rec;
    if (fin_v) q_r[wr_r + 2'(rec_v)] <= fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      rd_r <= rd_r + 2'(pop);
      wr_r <= wr_r + npush;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* sv/cipher_packet_stream_checker_top.sv */
`timescale 1ns / 1ps
// channel  ports                            dir
// input    in_valid/in_ready/in_data        in
// result   out_valid/out_ready/out_data     out
// config   cfg_we/cfg_wdata (strict_sizes)  in
// one byte per cycle; each byte is processed in the cycle it is accepted and
// its results land in a four-entry output fifo, visible the next cycle.
// in_ready drops only when the fifo cannot take two more results.
// rst_n is synchronous; strict_sizes resets to 1.
module cipher_packet_stream_checker_top #(
  parameter int MAX_FILE_BYTES = cpsc_pkg::MaxFileBytes,
  parameter int REGISTRY_ENTRIES = cpsc_pkg::RegistryEntries
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cpsc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import cpsc_pkg::*;

  logic strict_r;
  logic rec_v, fin_v, room;
  out_item_t rec, fin;

  always_ff @(posedge clk) begin
    if (!rst_n) strict_r <= 1'b1;
    else if (cfg_we) strict_r <= cfg_wdata;
  end

  assign in_ready = room;

  cpsc_core #(
    .MAX_FILE_BYTES(MAX_FILE_BYTES),
    .REGISTRY_ENTRIES(REGISTRY_ENTRIES)
  ) u_core (
    .clk(clk), .rst_n(rst_n), .strict(strict_r),
    .step(in_valid && room), .item(in_data),
    .rec_v(rec_v), .rec(rec), .fin_v(fin_v), .fin(fin)
  );

  cpsc_outq u_outq (
    .clk(clk), .rst_n(rst_n), .rec_v(rec_v), .rec(rec),
    .fin_v(fin_v), .fin(fin), .room(room),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

/* sim/cipher_packet_stream_checker_top_tb.sv */
`timescale 1ns / 1ps
module cipher_packet_stream_checker_top_tb;
  import cpsc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int RandomBytes = 2000;

  localparam logic [31:0] KnownTags [16] = '{
    32'h4f4d4544, 32'h444e4544, 32'h5359454b, 32'h45544152,
    32'h45564153, 32'h444e4553, 32'h454d4147, 32'h424d4854,
    32'h45524f4d, 32'h59414c50, 32'h504d4144, 32'h454d4143,
    32'h4e455241, 32'h45494c41, 32'h444e4146, 32'h4c4c5542};
  localparam int KnownSizes [16] = '{
    0, 0, 20, 4, 2, 0, 24, 3648, 52, 239, 724, 200, 1126, 814, 72, 252};

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  always #10 clk = ~clk;

  cipher_packet_stream_checker_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // checker state mirror
  logic strict_mode;
  int unsigned file_bytes;
  logic [31:0] size_word, stored_sum, running_sum;
  logic [7:0] key_now, key_step;
  logic [63:0] head_bytes;
  int unsigned bytes_due;
  phase_t walk_state;
  logic [3:0] walk_error;
  logic game_seen, game_short, game_capture;
  logic [31:0] game_word [4];

  out_item_t expected_results [$];
  int errors = 0;
  int unsigned cycles = 0;
  int sender_idle = 15, receiver_idle = 55;
  logic [7:0] file_data [$];
  logic [7:0] plain [$];

  task automatic clear_file_state();
    file_bytes = 0; size_word = 0; stored_sum = 0; running_sum = 0;
    key_now = 0; key_step = 0; head_bytes = 0; bytes_due = 0;
    walk_state = PH_ENV; walk_error = 0;
    game_seen = 0; game_short = 0; game_capture = 0;
    for (int i = 0; i < 4; i++) game_word[i] = 0;
  endtask

  function automatic int unsigned head_size();
    int unsigned sz;
    sz = head_bytes[63:32];
    return (sz > MaxFileBytes) ? MaxFileBytes : sz;
  endfunction

  task automatic packet_done(input int unsigned s);
    out_item_t r;
    int unsigned sz;
    sz = head_size();
    if (walk_error != 0) begin
      walk_state = PH_HALT;
      return;
    end
    r = '0;
    r.tag = head_bytes[31:0];
    r.packet_size = 23'(sz);
    r.packet_offset = 22'(s + 1 - 8 - sz);
    expected_results.insert(expected_results.size(), r);
    if (game_capture) begin
      game_seen = 1;
      if (sz < 24) game_short = 1;
      game_capture = 0;
    end
    if (head_bytes[31:0] == TagSend) walk_state = PH_SENT;
    else begin
      walk_state = PH_HEAD;
      bytes_due = 8;
    end
  endtask

  task automatic walk_packets(input logic [7:0] p, input int unsigned s);
    int hit;
    int unsigned pos;
    if (walk_state == PH_ENV) begin
      walk_state = PH_HEAD;
      bytes_due = 8;
    end
    case (walk_state)
      PH_HEAD: begin
        head_bytes = {p, head_bytes[63:8]};
        bytes_due--;
        if (bytes_due != 0) return;
        if (s == 7 && (head_bytes[31:0] != TagSave || head_bytes[63:32] != 2)) begin
          walk_error = ST_NO_SAVE;
          walk_state = PH_HALT;
          return;
        end
        hit = -1;
        for (int i = 0; i < 16; i++)
          if (hit < 0 && KnownTags[i] == head_bytes[31:0]) hit = i;
        if (hit < 0) walk_error = ST_UNKNOWN;
        else if (strict_mode && head_bytes[63:32] != KnownSizes[hit]) walk_error = ST_PKT_SIZE;
        game_capture = (head_bytes[31:0] == TagGame) && !game_seen;
        bytes_due = head_size();
        if (bytes_due == 0) packet_done(s);
        else walk_state = PH_BODY;
      end
      PH_BODY: begin
        if (game_capture) begin
          pos = head_size() - bytes_due;
          if (pos < 4) game_word[0][8*(pos%4) +: 8] |= p;
          else if (pos < 8) game_word[1][8*(pos%4) +: 8] |= p;
          else if (pos >= 12 && pos < 16) game_word[2][8*(pos%4) +: 8] |= p;
          else if (pos >= 16 && pos < 20) game_word[3][8*(pos%4) +: 8] |= p;
        end
        bytes_due--;
        if (bytes_due == 0) packet_done(s);
      end
      PH_SENT: begin
        walk_error = ST_TRUNC;
        walk_state = PH_HALT;
      end
      default: ;
    endcase
  endtask

  function automatic logic [3:0] file_verdict();
    logic signed [31:0] lvl, hp;
    lvl = game_word[1];
    hp = game_word[2];
    if (file_bytes < 18 || file_bytes > MaxFileBytes) return ST_SHORT;
    if (size_word != file_bytes) return ST_SIZE;
    if (stored_sum != running_sum) return ST_CHECKSUM;
    if (walk_state == PH_HALT) return walk_error;
    if (walk_state == PH_BODY) return ST_TRUNC;
    if (walk_state != PH_SENT) return ST_NO_SEND;
    if (!game_seen) return ST_NO_GAME;
    if (game_short) return ST_PKT_SIZE;
    if (lvl < 0 || lvl >= 6) return ST_LEVEL;
    if (hp < 1 || hp > 150) return ST_HEALTH;
    return ST_OK;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    logic [7:0] p;
    int unsigned idx;
    idx = file_bytes;
    if (idx < MaxFileBytes) begin
      p = b;
      if (idx < 4) size_word[8*idx +: 8] = b;
      else if (idx < 8) stored_sum[8*(idx-4) +: 8] = b;
      else running_sum += b;
      if (idx == 16) key_now = b;
      if (idx == 17) key_step = b;
      if (idx >= 18) begin
        p = b ^ key_now;
        key_now += key_step;
      end
      if (idx >= 8) walk_packets(p, idx - 8);
      file_bytes = idx + 1;
    end else file_bytes = MaxFileBytes + 1;
    if (last) begin
      r = '0;
      r.kind = 1;
      r.status = file_verdict();
      r.level_id = game_word[1];
      r.health = game_word[2];
      r.mode_field = game_word[0];
      r.death_count = game_word[3];
      r.final_res = 1;
      expected_results.insert(expected_results.size(), r);
      clear_file_state();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string nm, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", nm, got, want));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) report_mismatch("result with none expected");
      else begin
        w = expected_results.pop_front();
        check_field("kind", out_data.kind, w.kind);
        check_field("tag", out_data.tag, w.tag);
        check_field("packet_size", out_data.packet_size, w.packet_size);
        check_field("packet_offset", out_data.packet_offset, w.packet_offset);
        check_field("status", out_data.status, w.status);
        check_field("level_id", out_data.level_id, w.level_id);
        check_field("health", out_data.health, w.health);
        check_field("mode_field", out_data.mode_field, w.mode_field);
        check_field("death_count", out_data.death_count, w.death_count);
        check_field("final_res", out_data.final_res, w.final_res);
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle);
  end

  // one transaction on the input channel, mirror updated at acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{in_byte: b, last: last};
    do @(posedge clk); while (!in_ready);
    predict_byte(b, last);
  endtask

  task automatic write_strict(input logic v);
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    strict_mode = v;
    cfg_we <= 0;
  endtask

  task automatic add_word(input logic [31:0] v);
    for (int i = 0; i < 4; i++) plain.insert(plain.size(), v[8*i +: 8]);
  endtask

  task automatic add_packet(input logic [31:0] tag, input int sz);
    add_word(tag);
    add_word(sz);
    for (int i = 0; i < sz; i++) plain.insert(plain.size(), 8'($urandom_range(255)));
  endtask

  task automatic add_game();
    int sz;
    logic [31:0] lvl, hp;
    sz = ($urandom_range(9) == 0) ? 16 : 24;
    lvl = ($urandom_range(5) == 0) ? $urandom : $urandom_range(5);
    case ($urandom_range(7))
      0: hp = $urandom;
      1: hp = 150;
      2: hp = 1;
      3: hp = 151;
      default: hp = $urandom_range(150, 1);
    endcase
    add_word(TagGame);
    add_word(sz);
    add_word($urandom);
    add_word(lvl);
    add_word($urandom);
    if (sz > 12) add_word(hp);
    if (sz > 16) begin
      add_word($urandom);
      add_word($urandom);
    end
  endtask

  // well-formed file with random content, sometimes damaged
  task automatic build_file();
    logic [7:0] k, st;
    logic [31:0] sum;
    int n, t, pick;
    plain.delete();
    file_data.delete();
    k = 8'($urandom); st = 8'($urandom);
    add_word(TagSave); add_word(2);
    plain.insert(plain.size(), k); plain.insert(plain.size(), st);
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(6);
      case (pick)
        0: t = 0;
        1: t = 1;
        2: t = 2;
        3: t = 3;
        4: t = 8;
        5: t = 14;
        default: t = 15;
      endcase
      if ($urandom_range(15) == 0) add_packet($urandom, $urandom_range(4));
      else if ($urandom_range(9) == 0) add_packet(KnownTags[t], $urandom_range(30));
      else add_packet(KnownTags[t], KnownSizes[t]);
    end
    if ($urandom_range(9) != 0) add_game();
    if ($urandom_range(9) == 0) add_game();
    if ($urandom_range(9) != 0) add_packet(TagSend, 0);
    if ($urandom_range(9) == 0) add_packet(KnownTags[$urandom_range(15)], 0);
    for (int i = 0; i < plain.size(); i++) begin
      if (i >= 10) begin
        plain[i] ^= k;
        k += st;
      end
    end
    case ($urandom_range(9))
      0: repeat ($urandom_range(plain.size() - 1, 1)) void'(plain.pop_back());
      1: repeat ($urandom_range(3, 1)) plain.insert(plain.size(), 8'($urandom));
      default: ;
    endcase
    sum = 0;
    foreach (plain[i]) sum += plain[i];
    for (int i = 0; i < 4; i++)
      file_data.insert(file_data.size(), 8'(plain.size() + 8 >> 8*i));
    for (int i = 0; i < 4; i++) file_data.insert(file_data.size(), sum[8*i +: 8]);
    foreach (plain[i]) file_data.insert(file_data.size(), plain[i]);
    if ($urandom_range(9) == 0) begin
      pick = $urandom_range(file_data.size() - 1);
      file_data[pick] ^= 8'(1 << $urandom_range(7));
    end
  endtask

  typedef struct {
    logic [7:0] b;
    logic last;
    logic typed;
    logic [3:0] status;
  } stim_row_t;

  // bytes shorter than a file, then a zero file with a matching size word
  stim_row_t directed [20] = '{
    '{8'h00, 1, 1, ST_SHORT}, '{8'hff, 1, 1, ST_SHORT},
    '{8'd18, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 1, 1, ST_NO_SAVE}
  };

  initial begin
    int sent;
    strict_mode = 1;
    clear_file_state();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    foreach (directed[i]) begin
      send_byte(directed[i].b, directed[i].last);
      if (directed[i].typed) begin
        expected_results[$] = '0;
        expected_results[$].kind = 1;
        expected_results[$].status = directed[i].status;
        expected_results[$].final_res = 1;
      end
    end
    write_strict(0);
    sent = 0;
    while (sent < RandomBytes) begin
      if (sent > RandomBytes / 3 && sender_idle == 15) begin
        sender_idle = 55;
        receiver_idle = 15;
      end else if (sent > 2 * RandomBytes / 3 && sender_idle == 55) begin
        sender_idle = 0;
        receiver_idle = 0;
      end
      if ($urandom_range(3) == 0) write_strict($urandom_range(1));
      build_file();
      foreach (file_data[i]) send_byte(file_data[i], i == file_data.size() - 1);
      sent += file_data.size();
    end
    write_strict(1);
    build_file();
    foreach (file_data[i]) send_byte(file_data[i], i == file_data.size() - 1);
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
sv/cpsc_pkg.sv
sv/cpsc_core.sv
sv/cpsc_outq.sv
sv/cipher_packet_stream_checker_top.sv
sim/cipher_packet_stream_checker_top_tb.sv
